/* src/twcam_pkg.sv */
// Shared types and constants of the two-way clock affine mapper.
`default_nettype none

package twcam_pkg;

    // Sizing
    localparam int RING_DEPTH_DEF = 16;
    localparam int MIN_SAMPLES    = 4;
    localparam int DIGIT_W        = 8;
    localparam int RATE_QBITS     = 34;

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [2:0] ST_UNSYNC  = 3'd0;
    localparam logic [2:0] ST_WARMING = 3'd1;
    localparam logic [2:0] ST_VALID   = 3'd2;
    localparam logic [2:0] ST_STALE   = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // Fit constants
    localparam logic [35:0] MAX_AGE_RESET = 36'd1000000000;
    localparam logic [41:0] VAR_LIMIT     = 42'd4000000000000;
    localparam logic [6:0]  RATE_SCALE    = 7'd100;
    localparam logic [6:0]  RATE_LO       = 7'd99;
    localparam logic [6:0]  RATE_HI       = 7'd101;
    localparam logic [62:0] MASK63        = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] peer_session;
        logic [62:0] req_send_ns;
        logic [62:0] src_recv_ns;
        logic [62:0] src_send_ns;
        logic [62:0] req_recv_ns;
        logic [62:0] query_utc_ns;
        logic [62:0] now_ns;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        accepted;
        logic [4:0]  count;
        logic [63:0] session_out;
        logic [62:0] mapped_local_ns;
        logic [62:0] uncertainty_ns;
        logic [62:0] best_round_trip_ns;
        logic [62:0] age_ns;
        logic [32:0] rate_q32;
    } rsp_t;

    typedef struct packed {
        logic [63:0] source_mid_x2;
        logic [63:0] local_mid_x2;
        logic [62:0] trip_ns;
        logic [62:0] arrival_ns;
    } entry_t;

endpackage

`default_nettype wire

/* src/twcam_if.sv */
// Handshake channels of the two-way clock affine mapper.
`default_nettype none

interface twcam_req_if;
    logic               valid;
    logic               ready;
    twcam_pkg::req_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface twcam_rsp_if;
    logic               valid;
    logic               ready;
    twcam_pkg::rsp_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface twcam_cfg_if;
    logic               valid;
    logic               ready;
    logic [35:0]        data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/twcam_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module twcam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/twcam_mul.sv */
// Shared signed multiplier, one byte of the multiplier operand per cycle.
`default_nettype none

module twcam_mul #(
    parameter int W  = 190,
    parameter int BW = 77
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [W-1:0] a,
    input  wire logic signed [W-1:0] b,
    output logic                     done,
    output logic signed [W-1:0]      p
);

    import twcam_pkg::*;

    logic signed [W-1:0]       a_reg;
    logic signed [W-1:0]       acc_reg;
    logic signed [W-1:0]       p_reg;
    logic signed [W-1:0]       b_abs;
    logic [BW-1:0]             bmag_reg;
    logic                      neg_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [DIGIT_W:0]   digit;

    // Work on the magnitude of b, fix the sign at the end
    assign b_abs = b[W-1] ? -b : b;
    assign digit = $signed({1'b0, bmag_reg[DIGIT_W-1:0]});

    // Accumulate one digit per cycle, stop once the remaining digits are zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            acc_reg  <= '0;
            p_reg    <= '0;
            bmag_reg <= '0;
            neg_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            a_reg    <= a;
            bmag_reg <= b_abs[BW-1:0];
            neg_reg  <= b[W-1];
            acc_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (bmag_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                p_reg    <= neg_reg ? -acc_reg : acc_reg;
            end
            else
            begin
                acc_reg  <= acc_reg + a_reg * digit;
                a_reg    <= a_reg <<< DIGIT_W;
                bmag_reg <= bmag_reg >> DIGIT_W;
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

`default_nettype wire

/* src/two_way_clock_affine_mapper.sv */
// Top level: sample ring, fit sequencer and result register of the clock mapper.
`default_nettype none

// Add, clear and unused commands pass through the DONE state alone; their item
// is loaded into the rsp output register from DONE, and waits in DONE while an
// earlier item still waits on rsp. A query walks the held samples three times
// through one ring read port: a scan for newest and shortest-round-trip
// samples, a sum pass, a 34-step restoring division for the rate, then a
// residual pass; the sum and residual passes feed one shared multiplier taking
// one byte of its second operand per cycle. req.ready is high only while no
// item is in progress. The ring needs no clearing pass: only slots written
// since the last clear are read.
module two_way_clock_affine_mapper #(
    parameter int RING_DEPTH = twcam_pkg::RING_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    twcam_req_if.sink   req,
    twcam_rsp_if.source rsp,
    twcam_cfg_if.sink   cfg
);

    import twcam_pkg::*;

    localparam int SW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int W  = 2 * CW + 180;
    localparam int BW = 72 + CW;
    localparam int EW = $bits(entry_t);
    localparam logic signed [W-1:0] HALF_UNIT = W'(64'h1_0000_0000);

    typedef enum logic [5:0] {
        IDLE, SCAN_RD, SCAN_USE, BEST_RD, BEST_USE,
        SUM_RD, SUM_USE, SQ_WT, XP_GO, XP_WT,
        CN_A_GO, CN_A_WT, CN_B_GO, CN_B_WT,
        VN_A_GO, VN_A_WT, VN_B_GO, VN_B_WT,
        VL_GO, VL_WT, C100_GO, C100_WT, V99_GO, V99_WT, V101_GO, V101_WT,
        DIV, MAP_GO, MAP_WT, RES_RD, RES_USE, RES_WT, FINAL, DONE
    } state_t;

    state_t                  state_reg;
    logic [35:0]             max_age_reg;
    logic [SW-1:0]           slot_reg;
    logic [CW-1:0]           count_reg;
    logic [63:0]             session_reg;
    logic [2:0]              status_reg;
    logic [62:0]             q_reg;
    logic [62:0]             now_reg;
    logic [CW-1:0]           idx_reg;
    logic [62:0]             newest_reg;
    logic [SW-1:0]           best_idx_reg;
    logic [62:0]             best_trip_reg;
    logic [63:0]             s0_reg;
    logic [63:0]             l0_reg;
    logic [63:0]             sb_reg;
    logic [63:0]             lb_reg;
    logic [62:0]             tb_reg;
    logic signed [64:0]      ds_reg;
    logic signed [64:0]      dl_reg;
    logic signed [W-1:0]     sds_reg;
    logic signed [W-1:0]     sdl_reg;
    logic signed [W-1:0]     sss_reg;
    logic signed [W-1:0]     ssl_reg;
    logic signed [W-1:0]     t_reg;
    logic signed [W-1:0]     cn_reg;
    logic signed [W-1:0]     vn_reg;
    logic signed [W-1:0]     rem_reg;
    logic signed [W-1:0]     dsh_reg;
    logic signed [W-1:0]     mres_reg;
    logic [RATE_QBITS-1:0]   r_reg;
    logic [5:0]              qcnt_reg;
    rsp_t                    res_reg;
    rsp_t                    out_data_reg;
    logic                    out_valid_reg;

    logic                    accept;
    logic                    bad_sample;
    logic                    new_session;
    logic [62:0]             rt_c;
    logic [62:0]             pr_c;
    logic [SW-1:0]           slot_eff;
    logic [CW-1:0]           count_eff;
    logic [SW-1:0]           slot_nx;
    logic [CW-1:0]           count_nx;
    logic                    ram_we;
    entry_t                  wr_entry;
    logic [EW-1:0]           rd_data;
    entry_t                  rd_entry;
    logic [SW-1:0]           rd_addr;
    logic                    last_idx;
    logic signed [64:0]      ds_c;
    logic signed [64:0]      dl_c;
    logic signed [64:0]      sd_c;
    logic signed [64:0]      ld_c;
    logic signed [64:0]      qd_c;
    logic [62:0]             age_c;
    logic signed [W-1:0]     num_c;
    logic [W-1:0]            rnd_c;
    logic signed [W-1:0]     e_c;
    logic signed [W-1:0]     eabs_c;
    logic [W-1:0]            u_c;
    logic                    div_take;
    logic                    mul_start;
    logic signed [W-1:0]     mul_a;
    logic signed [W-1:0]     mul_b;
    logic                    mul_done;
    logic signed [W-1:0]     mul_p;
    rsp_t                    done_c;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Check an incoming sample
    assign rt_c = req.data.req_recv_ns - req.data.req_send_ns;
    assign pr_c = req.data.src_send_ns - req.data.src_recv_ns;
    assign bad_sample = (req.data.peer_session == '0) || (req.data.req_send_ns == '0)
                     || (req.data.src_recv_ns == '0)
                     || (req.data.src_send_ns < req.data.src_recv_ns)
                     || (req.data.req_recv_ns < req.data.req_send_ns)
                     || (pr_c > rt_c);
    assign new_session = (session_reg != '0) && (session_reg != req.data.peer_session);
    assign slot_eff    = new_session ? '0 : slot_reg;
    assign count_eff   = new_session ? '0 : count_reg;
    assign slot_nx     = (slot_eff == SW'(RING_DEPTH - 1)) ? '0 : slot_eff + SW'(1);
    assign count_nx    = (count_eff == CW'(RING_DEPTH)) ? count_eff : count_eff + CW'(1);

    // Build the stored entry
    assign wr_entry.source_mid_x2 = {1'b0, req.data.src_recv_ns} + {1'b0, req.data.src_send_ns};
    assign wr_entry.local_mid_x2  = {1'b0, req.data.req_send_ns} + {1'b0, req.data.req_recv_ns};
    assign wr_entry.trip_ns       = rt_c - pr_c;
    assign wr_entry.arrival_ns    = req.data.req_recv_ns;
    assign ram_we = accept && (req.data.cmd == CMD_ADD) && !bad_sample;

    assign rd_addr  = (state_reg == BEST_RD) ? best_idx_reg : idx_reg[SW-1:0];
    assign rd_entry = entry_t'(rd_data);

    twcam_ram #(
        .WIDTH (EW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (slot_eff),
        .wr_data (EW'(wr_entry)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Differences against sample zero and against the anchor
    assign last_idx = ((idx_reg + CW'(1)) == count_reg);
    assign ds_c = $signed({1'b0, rd_entry.source_mid_x2}) - $signed({1'b0, s0_reg});
    assign dl_c = $signed({1'b0, rd_entry.local_mid_x2}) - $signed({1'b0, l0_reg});
    assign sd_c = $signed({1'b0, rd_entry.source_mid_x2}) - $signed({1'b0, sb_reg});
    assign ld_c = $signed({1'b0, rd_entry.local_mid_x2}) - $signed({1'b0, lb_reg});
    assign qd_c = $signed({1'b0, q_reg, 1'b0}) - $signed({1'b0, sb_reg});
    assign age_c = now_reg - newest_reg;

    // Mapping, residual and uncertainty arithmetic
    assign num_c    = (W'($signed({1'b0, lb_reg})) <<< 32) + mul_p;
    assign rnd_c    = (num_c + HALF_UNIT) >> 33;
    assign e_c      = t_reg - mul_p;
    assign eabs_c   = e_c[W-1] ? -e_c : e_c;
    assign u_c      = ((W'({1'b0, tb_reg}) << 32) + mres_reg + HALF_UNIT) >> 33;
    assign div_take = (rem_reg >= dsh_reg);

    // Select operands for the shared multiplier
    always_comb
    begin
        mul_start = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            SUM_USE:
            begin
                mul_a = W'(ds_c);
                mul_b = W'(ds_c);
            end
            XP_GO:
            begin
                mul_a = W'(dl_reg);
                mul_b = W'(ds_reg);
            end
            CN_A_GO:
            begin
                mul_a = ssl_reg;
                mul_b = W'(count_reg);
            end
            CN_B_GO:
            begin
                mul_a = sdl_reg;
                mul_b = sds_reg;
            end
            VN_A_GO:
            begin
                mul_a = sss_reg;
                mul_b = W'(count_reg);
            end
            VN_B_GO:
            begin
                mul_a = sds_reg;
                mul_b = sds_reg;
            end
            VL_GO:
            begin
                mul_a = W'(VAR_LIMIT);
                mul_b = W'(count_reg);
            end
            C100_GO:
            begin
                mul_a = cn_reg;
                mul_b = W'(RATE_SCALE);
            end
            V99_GO:
            begin
                mul_a = vn_reg;
                mul_b = W'(RATE_LO);
            end
            V101_GO:
            begin
                mul_a = vn_reg;
                mul_b = W'(RATE_HI);
            end
            MAP_GO:
            begin
                mul_a = W'(qd_c);
                mul_b = W'(r_reg);
            end
            RES_USE:
            begin
                mul_a = W'(sd_c);
                mul_b = W'(r_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    twcam_mul #(
        .W  (W),
        .BW (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Result item with the held count and session after the step
    always_comb
    begin
        done_c             = res_reg;
        done_c.count       = 5'(count_reg);
        done_c.session_out = session_reg;
    end

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= MAX_AGE_RESET;
        end
        else if (cfg.valid)
        begin
            max_age_reg <= cfg.data;
        end
    end

    // Sequencer, held state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            slot_reg      <= '0;
            count_reg     <= '0;
            session_reg   <= '0;
            status_reg    <= ST_UNSYNC;
            q_reg         <= '0;
            now_reg       <= '0;
            idx_reg       <= '0;
            newest_reg    <= '0;
            best_idx_reg  <= '0;
            best_trip_reg <= '0;
            s0_reg        <= '0;
            l0_reg        <= '0;
            sb_reg        <= '0;
            lb_reg        <= '0;
            tb_reg        <= '0;
            ds_reg        <= '0;
            dl_reg        <= '0;
            sds_reg       <= '0;
            sdl_reg       <= '0;
            sss_reg       <= '0;
            ssl_reg       <= '0;
            t_reg         <= '0;
            cn_reg        <= '0;
            vn_reg        <= '0;
            rem_reg       <= '0;
            dsh_reg       <= '0;
            mres_reg      <= '0;
            r_reg         <= '0;
            qcnt_reg      <= '0;
            res_reg       <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless a new one is loaded now
            if (out_valid_reg && rsp.ready && (state_reg != DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= DONE;
                        case (req.data.cmd)
                            CMD_ADD:
                            begin
                                if (bad_sample)
                                begin
                                    slot_reg       <= '0;
                                    count_reg      <= '0;
                                    session_reg    <= '0;
                                    status_reg     <= ST_INVALID;
                                    res_reg.status <= ST_INVALID;
                                end
                                else
                                begin
                                    slot_reg         <= slot_nx;
                                    count_reg        <= count_nx;
                                    session_reg      <= req.data.peer_session;
                                    status_reg       <= ST_WARMING;
                                    res_reg.status   <= ST_WARMING;
                                    res_reg.accepted <= 1'b1;
                                end
                            end
                            CMD_QUERY:
                            begin
                                q_reg   <= req.data.query_utc_ns;
                                now_reg <= req.data.now_ns;
                                idx_reg <= '0;
                                if ((req.data.query_utc_ns == '0) || (session_reg == '0)
                                    || (count_reg == '0))
                                begin
                                    res_reg.status <= status_reg;
                                end
                                else if ((req.data.now_ns == '0) || (max_age_reg == '0))
                                begin
                                    res_reg.status <= ST_INVALID;
                                end
                                else
                                begin
                                    state_reg <= SCAN_RD;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                slot_reg       <= '0;
                                count_reg      <= '0;
                                session_reg    <= '0;
                                status_reg     <= ST_UNSYNC;
                                res_reg.status <= ST_UNSYNC;
                            end
                            default:
                            begin
                                res_reg.status <= status_reg;
                            end
                        endcase
                    end
                end

                SCAN_RD:
                begin
                    state_reg <= SCAN_USE;
                end

                // Track newest arrival and shortest trip, first slot wins ties
                SCAN_USE:
                begin
                    if (idx_reg == '0)
                    begin
                        newest_reg    <= rd_entry.arrival_ns;
                        best_trip_reg <= rd_entry.trip_ns;
                        best_idx_reg  <= '0;
                        s0_reg        <= rd_entry.source_mid_x2;
                        l0_reg        <= rd_entry.local_mid_x2;
                    end
                    else
                    begin
                        if (rd_entry.arrival_ns > newest_reg)
                        begin
                            newest_reg <= rd_entry.arrival_ns;
                        end
                        if (rd_entry.trip_ns < best_trip_reg)
                        begin
                            best_trip_reg <= rd_entry.trip_ns;
                            best_idx_reg  <= idx_reg[SW-1:0];
                        end
                    end
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= last_idx ? BEST_RD : SCAN_RD;
                end

                BEST_RD:
                begin
                    state_reg <= BEST_USE;
                end

                // Latch the anchor and judge age and sample count
                BEST_USE:
                begin
                    sb_reg    <= rd_entry.source_mid_x2;
                    lb_reg    <= rd_entry.local_mid_x2;
                    tb_reg    <= rd_entry.trip_ns;
                    idx_reg   <= '0;
                    sds_reg   <= '0;
                    sdl_reg   <= '0;
                    sss_reg   <= '0;
                    ssl_reg   <= '0;
                    state_reg <= DONE;
                    if (now_reg < newest_reg)
                    begin
                        res_reg.status <= ST_INVALID;
                    end
                    else
                    begin
                        res_reg.age_ns <= age_c;
                        if (age_c > 63'(max_age_reg))
                        begin
                            res_reg.status <= ST_STALE;
                        end
                        else if (count_reg < CW'(MIN_SAMPLES))
                        begin
                            res_reg.status <= ST_WARMING;
                        end
                        else
                        begin
                            state_reg <= SUM_RD;
                        end
                    end
                end

                SUM_RD:
                begin
                    state_reg <= SUM_USE;
                end

                // Accumulate first sums; the square starts here
                SUM_USE:
                begin
                    ds_reg    <= ds_c;
                    dl_reg    <= dl_c;
                    sds_reg   <= sds_reg + W'(ds_c);
                    sdl_reg   <= sdl_reg + W'(dl_c);
                    state_reg <= SQ_WT;
                end

                SQ_WT:
                begin
                    if (mul_done)
                    begin
                        sss_reg   <= sss_reg + mul_p;
                        state_reg <= XP_GO;
                    end
                end

                XP_GO:
                begin
                    state_reg <= XP_WT;
                end

                XP_WT:
                begin
                    if (mul_done)
                    begin
                        ssl_reg   <= ssl_reg + mul_p;
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= last_idx ? CN_A_GO : SUM_RD;
                    end
                end

                // Covariance and variance terms
                CN_A_GO:
                begin
                    state_reg <= CN_A_WT;
                end

                CN_A_WT:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= mul_p;
                        state_reg <= CN_B_GO;
                    end
                end

                CN_B_GO:
                begin
                    state_reg <= CN_B_WT;
                end

                CN_B_WT:
                begin
                    if (mul_done)
                    begin
                        cn_reg    <= t_reg - mul_p;
                        state_reg <= VN_A_GO;
                    end
                end

                VN_A_GO:
                begin
                    state_reg <= VN_A_WT;
                end

                VN_A_WT:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= mul_p;
                        state_reg <= VN_B_GO;
                    end
                end

                VN_B_GO:
                begin
                    state_reg <= VN_B_WT;
                end

                VN_B_WT:
                begin
                    if (mul_done)
                    begin
                        vn_reg    <= t_reg - mul_p;
                        state_reg <= VL_GO;
                    end
                end

                // Reject too small a source spread
                VL_GO:
                begin
                    state_reg <= VL_WT;
                end

                VL_WT:
                begin
                    if (mul_done)
                    begin
                        if (vn_reg < mul_p)
                        begin
                            res_reg.status <= ST_WARMING;
                            state_reg      <= DONE;
                        end
                        else
                        begin
                            state_reg <= C100_GO;
                        end
                    end
                end

                // Rate window check
                C100_GO:
                begin
                    state_reg <= C100_WT;
                end

                C100_WT:
                begin
                    if (mul_done)
                    begin
                        t_reg     <= mul_p;
                        state_reg <= V99_GO;
                    end
                end

                V99_GO:
                begin
                    state_reg <= V99_WT;
                end

                V99_WT:
                begin
                    if (mul_done)
                    begin
                        if (t_reg < mul_p)
                        begin
                            res_reg.status <= ST_INVALID;
                            state_reg      <= DONE;
                        end
                        else
                        begin
                            state_reg <= V101_GO;
                        end
                    end
                end

                V101_GO:
                begin
                    state_reg <= V101_WT;
                end

                V101_WT:
                begin
                    if (mul_done)
                    begin
                        if (t_reg > mul_p)
                        begin
                            res_reg.status <= ST_INVALID;
                            state_reg      <= DONE;
                        end
                        else
                        begin
                            rem_reg   <= (cn_reg <<< 33) + vn_reg;
                            dsh_reg   <= vn_reg <<< RATE_QBITS;
                            r_reg     <= '0;
                            qcnt_reg  <= 6'(RATE_QBITS - 1);
                            state_reg <= DIV;
                        end
                    end
                end

                // Rounded rate, one quotient bit per cycle
                DIV:
                begin
                    if (div_take)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    r_reg   <= {r_reg[RATE_QBITS-2:0], div_take};
                    dsh_reg <= dsh_reg >>> 1;
                    if (qcnt_reg == '0)
                    begin
                        state_reg <= MAP_GO;
                    end
                    else
                    begin
                        qcnt_reg <= qcnt_reg - 6'd1;
                    end
                end

                MAP_GO:
                begin
                    state_reg <= MAP_WT;
                end

                // Map the query time through the anchor
                MAP_WT:
                begin
                    if (mul_done)
                    begin
                        if (num_c[W-1] || (num_c == '0) || (|rnd_c[W-1:63]))
                        begin
                            res_reg.status <= ST_INVALID;
                            state_reg      <= DONE;
                        end
                        else
                        begin
                            res_reg.mapped_local_ns <= rnd_c[62:0];
                            idx_reg                 <= '0;
                            mres_reg                <= '0;
                            state_reg               <= RES_RD;
                        end
                    end
                end

                RES_RD:
                begin
                    state_reg <= RES_USE;
                end

                RES_USE:
                begin
                    t_reg     <= W'(ld_c) <<< 32;
                    state_reg <= RES_WT;
                end

                // Keep the largest residual
                RES_WT:
                begin
                    if (mul_done)
                    begin
                        if (eabs_c > mres_reg)
                        begin
                            mres_reg <= eabs_c;
                        end
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= last_idx ? FINAL : RES_RD;
                    end
                end

                FINAL:
                begin
                    res_reg.status             <= ST_VALID;
                    res_reg.uncertainty_ns     <= (|u_c[W-1:63]) ? MASK63 : u_c[62:0];
                    res_reg.best_round_trip_ns <= tb_reg;
                    res_reg.rate_q32           <= r_reg[32:0];
                    state_reg                  <= DONE;
                end

                // Hand the item to the output register when it is free
                DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_data_reg  <= done_c;
                        out_valid_reg <= 1'b1;
                        res_reg       <= '0;
                        state_reg     <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/twcam_chk.sv */
// Port-level checks of the clock mapper, bound to the top level.
`default_nettype none

module twcam_chk (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_ready,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire twcam_pkg::rsp_t rsp_data
);

    import twcam_pkg::*;

    // A stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result item changed while stalled");

    // One item in progress at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while another is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status <= ST_INVALID)
        else $error("status code out of range");

    // Fit fields only carry values for a valid mapping
    a_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_VALID) |->
            (rsp_data.mapped_local_ns == '0) && (rsp_data.uncertainty_ns == '0)
            && (rsp_data.best_round_trip_ns == '0) && (rsp_data.rate_q32 == '0))
        else $error("fit fields set without a valid mapping");

    // A stored sample leaves the block warming with a sample held
    a_accept_warm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.accepted |->
            (rsp_data.status == ST_WARMING) && (rsp_data.count != '0))
        else $error("accepted sample without warming status");

endmodule

bind two_way_clock_affine_mapper twcam_chk u_twcam_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
